>>> sv/sdss_pkg.sv
package sdss_pkg;

    localparam int DATA_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int MAX_DIGITS = 8;
    localparam int POS_W      = 3;
    localparam int SEG_W      = 8;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = $clog2(DATA_W);

    localparam logic [DIGIT_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [DIGIT_W-1:0] CODE_BLANK = 4'd15;

    typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    typedef struct packed {
        logic load;
        logic step;
    } t_step_ctl;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:       seg = 8'h3F;
            4'd1:       seg = 8'h06;
            4'd2:       seg = 8'h5B;
            4'd3:       seg = 8'h4F;
            4'd4:       seg = 8'h66;
            4'd5:       seg = 8'h6D;
            4'd6:       seg = 8'h7D;
            4'd7:       seg = 8'h07;
            4'd8:       seg = 8'h7F;
            4'd9:       seg = 8'h6F;
            CODE_MINUS: seg = 8'h40;
            default:    seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> sv/sdss_bcd.sv
module sdss_bcd (
    input  logic               i_clk,
    input  sdss_pkg::t_step_ctl i_ctl,
    input  logic [sdss_pkg::DATA_W-1:0] i_value,
    output sdss_pkg::t_bcd     o_digits
);
    import sdss_pkg::*;

    // shift-and-add-3: one binary bit enters the decimal digits per step
    logic [DATA_W-1:0] r_bin;
    t_bcd              r_bcd;
    t_bcd              adj;
    logic [BCD_W-1:0]  adj_flat;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        adj_flat = adj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_ctl.step) begin
            r_bin <= {r_bin[DATA_W-2:0], 1'b0};
            r_bcd <= {adj_flat[BCD_W-2:0], r_bin[DATA_W-1]};
        end
    end

    assign o_digits = r_bcd;

endmodule

>>> sv/sdss_div.sv
module sdss_div (
    input  logic               i_clk,
    input  sdss_pkg::t_step_ctl i_ctl,
    input  logic [sdss_pkg::DATA_W-1:0] i_dividend,
    input  logic [sdss_pkg::CNT_W-1:0]  i_divisor,
    output logic [sdss_pkg::DATA_W-1:0] o_quotient
);
    import sdss_pkg::*;

    // restoring division, one quotient bit per step; divisor is 1..8
    logic [DATA_W-1:0] r_quo;
    logic [POS_W-1:0]  r_rem;
    logic [CNT_W-1:0]  trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign fits  = (trial >= i_divisor);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[DATA_W-2:0], fits};
            r_rem <= fits ? POS_W'(trial - i_divisor) : trial[POS_W-1:0];
        end
    end

    assign o_quotient = r_quo;

endmodule

>>> sv/signed_decimal_seven_segment_scan.sv
// Scan driver for a multiplexed seven-segment display. Each input transaction
// carries a signed 32-bit number and a total display time in microseconds;
// the block answers with one output transaction per display position, left
// to right, carrying the segment pattern (a..g, dp, inverted for common
// anode), the common line level, a blank flag, and the dwell time (total
// divided by the position count); tlast marks the rightmost position. Digits
// fill from the right, a minus sign follows if a position is free, zero shows
// as a single 0, and digits that do not fit are dropped from the high end.
// A new item waits until the last is through: tready stays low from acceptance
// until the last position (of 1..8) enters the output register. The bit-serial
// binary-to-decimal shifter and divider run side by side, one bit each per
// cycle, then the positions follow in turn, held while the output stalls. The
// user must write configuration (APB, digit_count at 0x0, common_cathode at
// 0x4) only while idle; the block itself does not enforce this.
module signed_decimal_seven_segment_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] signed_number, [63:32] total_time_us
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [2:0] position, [10:3] segments,
                                          // [11] common_level, [43:12] dwell_us, pad
    output logic        o_m_axis_tuser,   // [0] blank
    output logic        o_m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdss_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic REG_DIGIT_COUNT    = 1'b0;
    localparam logic REG_COMMON_CATHODE = 1'b1;

    // configuration registers
    logic [CNT_W-1:0] r_digit_count;
    logic             r_common_cathode;

    // sequencer
    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_cnt;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_last_pos;
    logic              r_neg;
    logic [POS_W-1:0]  n_last_pos;

    // output register
    logic              r_m_valid;
    logic [POS_W-1:0]  r_m_pos;
    logic [SEG_W-1:0]  r_m_seg;
    logic              r_m_com;
    logic              r_m_blank;
    logic [DATA_W-1:0] r_m_dwell;
    logic              r_m_last;

    logic              s_accept;
    logic              cfg_write;
    logic              emit_load;
    t_step_ctl         unit_ctl;
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] magnitude;
    t_bcd              digits;
    logic [DATA_W-1:0] dwell;
    logic [MAX_DIGITS-1:0] sig;
    logic [POS_W-1:0]  dig_idx;
    logic [DIGIT_W-1:0] code;
    logic [SEG_W-1:0]  seg;
    logic              com;
    logic              blank;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_COMMON_CATHODE) ? {31'b0, r_common_cathode}
                                                        : {28'b0, r_digit_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count    <= 4'd4;
            r_common_cathode <= 1'b1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_DIGIT_COUNT) begin
                r_digit_count <= pwdata[CNT_W-1:0];
            end else begin
                r_common_cathode <= pwdata[0];
            end
        end
    end

    // clamp the position count to 1..MAX_DIGITS, held as the index of the last position
    always_comb begin
        if (r_digit_count == '0) begin
            n_last_pos = '0;
        end else if (r_digit_count > CNT_W'(MAX_DIGITS)) begin
            n_last_pos = POS_W'(MAX_DIGITS - 1);
        end else begin
            n_last_pos = POS_W'(r_digit_count - 4'd1);
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // take the magnitude once at acceptance; the most negative number wraps to 2^31
    assign raw       = i_s_axis_tdata[DATA_W-1:0];
    assign magnitude = raw[DATA_W-1] ? DATA_W'(-raw) : raw;

    assign unit_ctl.load = s_accept;
    assign unit_ctl.step = (r_state == ST_CONV);

    sdss_bcd u_bcd (
        .i_clk    (i_clk),
        .i_ctl    (unit_ctl),
        .i_value  (magnitude),
        .o_digits (digits)
    );

    sdss_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (unit_ctl),
        .i_dividend (i_s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_divisor  ({1'b0, r_last_pos} + CNT_W'(1)),
        .o_quotient (dwell)
    );

    // a digit index is significant when it or any higher digit is nonzero;
    // the units digit always shows so that zero reads as a single 0
    always_comb begin
        sig = '0;
        for (int jj = 0; jj < MAX_DIGITS; jj++) begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                if (i >= jj && digits[i] != '0) begin
                    sig[jj] = 1'b1;
                end
            end
        end
        sig[0] = 1'b1;
    end

    // leftmost position maps to the highest shown digit index
    assign dig_idx = r_last_pos - r_pos;

    always_comb begin
        if (sig[dig_idx]) begin
            code = digits[dig_idx];
        end else if (r_neg && sig[POS_W'(dig_idx - 3'd1)]) begin
            code = CODE_MINUS;
        end else begin
            code = CODE_BLANK;
        end
        blank = (code > CODE_MINUS);
        seg   = seg_of(code);
        com   = 1'b0;
        if (!blank && !r_common_cathode) begin
            seg = ~seg;
            com = 1'b1;
        end
    end

    assign emit_load = (r_state == ST_EMIT) && (!r_m_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_state <= ST_CONV;
                        r_cnt   <= '0;
                    end
                end
                ST_CONV: begin
                    // advance one bit per cycle through both serial units
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(DATA_W - 1)) begin
                        r_state <= ST_EMIT;
                        r_pos   <= '0;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_pos <= r_pos + POS_W'(1);
                        if (r_pos == r_last_pos) begin
                            r_state <= ST_IDLE;
                            r_pos   <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_last_pos <= n_last_pos;
            r_neg      <= raw[DATA_W-1];
        end
    end

    // output register: hold a result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_m_pos   <= r_pos;
            r_m_seg   <= blank ? '0 : seg;
            r_m_com   <= com;
            r_m_blank <= blank;
            r_m_dwell <= dwell;
            r_m_last  <= (r_pos == r_last_pos);
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0, r_m_dwell, r_m_com, r_m_seg, r_m_pos};
    assign o_m_axis_tuser  = r_m_blank;
    assign o_m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[2:0] == r_last_pos)
        else $error("tlast on a position other than the last one");

    a_blank_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[11:3] == '0)
        else $error("blank position drives a segment or common line");

    a_scan_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside a scan");
`endif

endmodule
